// ===== hdl/fwa_pkg.sv =====
// Shared types and constants for the FFT data window block.
// No dependencies; the top level refers to it by scoped names.
package fwa_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HANN_ADDR,
        S_HANN_W,
        S_SQ_T,
        S_SQ_T_RES,
        S_SQ_U,
        S_SQ_U_RES,
        S_SCL_RE,
        S_SCL_IM,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WIN_SQUARE = 3'd0,
        WIN_HANN   = 3'd1,
        WIN_PARZEN = 3'd2,
        WIN_WELCH  = 3'd3,
        WIN_QUAD   = 3'd4
    } t_win;

    localparam logic [7:0] REG_WINDOW_TYPE  = 8'd0;
    localparam logic [7:0] REG_SAMPLE_COUNT = 8'd1;
    localparam logic [7:0] REG_MEAN_OFFSET  = 8'd2;
    localparam logic [7:0] REG_COMPLEX_MODE = 8'd3;

endpackage

// ===== hdl/fft_window_apply.sv =====
// Top level of the pre-FFT data window: registers, sequencer, output register.
// Uses fwa_pkg, fwa_div, fwa_cos_rom and fwa_mul.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+------------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: sample_re, sample_im
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: windowed_re, windowed_im;
//            |           |                              | tlast: frame_last
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One transaction at a time goes through the bit-per-cycle divider. A sample holds the input
// while it passes the divider (all but square), the Hann table read, the squaring steps (Welch
// one, quadratic two) and the re and im scaling; the divider yields QW quotient bits, with
// QW = max(COEF_FRAC_BITS+1, log2(4*COS_TABLE_DEPTH)). The result appears in the cycle the next sample can be accepted.
// The multiplier is shared for squaring and for scaling re and im.
// Reset is synchronous; registers return to their defaults and the frame index to zero.
// A finished result waits in the output register while the next sample is accepted;
// a second finished result holds the sequencer until m_axis_tready frees that register.
module fft_window_apply #(
    parameter int MAX_FRAME       = 65536,
    parameter int COEF_FRAC_BITS  = 18,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample_re, [63:32] sample_im
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] windowed_re, [63:32] windowed_im
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int F     = COEF_FRAC_BITS;
    localparam int D     = COS_TABLE_DEPTH;
    localparam int NBITS = $clog2(MAX_FRAME + 1);
    localparam int IDXW  = $clog2(MAX_FRAME);
    localparam int D8W   = $clog2(8 * D + 1);
    localparam int NUMW  = NBITS + ((F > D8W) ? F : D8W) + 1;
    localparam int DENW  = NBITS + 1;
    localparam int PHW   = $clog2(4 * D);
    localparam int QW    = ((F + 1) > PHW) ? (F + 1) : PHW;
    localparam int AW    = $clog2(D + 1);
    localparam int VW    = 33;
    localparam int MBW   = F + 2;
    localparam int PW    = VW + MBW;
    localparam int DW    = fwa_pkg::DATA_W;

    localparam logic [F:0]           W_ONE    = (F + 1)'(1) << F;
    localparam logic [PW-1:0]        RND_U    = PW'(1) << (F - 1);
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (F - 1);
    localparam logic signed [PW-1:0] SAT_HI   = PW'(32'h7FFFFFFF);
    localparam logic signed [PW-1:0] SAT_LO   = -SAT_HI - PW'(1);

    function automatic logic [DW-1:0] scale_out(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] q;
        q = (p + RND_HALF) >>> F;
        if (q > SAT_HI) return 32'h7FFFFFFF;
        else if (q < SAT_LO) return 32'h80000000;
        else return q[DW-1:0];
    endfunction

    // Configuration and frame state
    logic [2:0]          r_window_type;
    logic [16:0]         r_sample_count;
    logic [DW-1:0]       r_mean_offset;
    logic                r_complex_mode;
    logic [IDXW-1:0]     r_index;

    // Per-sample working registers
    fwa_pkg::t_state     r_state;
    fwa_pkg::t_state     n_state;
    logic [2:0]          r_kind;
    logic                r_cplx;
    logic                r_last;
    logic signed [VW-1:0] r_v_re;
    logic signed [VW-1:0] r_v_im;
    logic [F:0]          r_w;
    logic [F:0]          r_t;
    logic [DW-1:0]       r_res_re;
    logic                r_out_valid;
    logic [DW-1:0]       r_out_re;
    logic [DW-1:0]       r_out_im;
    logic                r_out_last;

    logic                w_accept;
    logic [31:0]         w_sc_ext;
    logic [NBITS-1:0]    w_n;
    logic [IDXW-1:0]     w_i;
    logic                w_last;
    logic [NUMW-1:0]     w_nn;
    logic [NUMW-1:0]     w_two_i;
    logic [NUMW-1:0]     w_two_i1;
    logic [NUMW-1:0]     w_d_pw;
    logic [NUMW-1:0]     w_d_q;
    logic [NUMW-1:0]     w_num;
    logic [DENW-1:0]     w_den;
    logic                w_need_div;
    logic                w_div_busy;
    logic                w_div_done;
    logic [QW-1:0]       w_quot;
    logic [PHW-1:0]      w_p;
    logic [PHW-1:0]      w_rr;
    logic [1:0]          w_quad;
    logic                w_neg;
    logic [AW-1:0]       w_rom_addr;
    logic [F:0]          w_rom_data;
    logic [F+2:0]        w_hann_tmp;
    logic signed [VW-1:0]  w_mul_a;
    logic signed [MBW-1:0] w_mul_b;
    logic signed [PW-1:0]  w_prod;
    logic [PW-1:0]       w_rnd_tmp;
    logic [F:0]          w_rnd;
    logic                w_out_free;
    logic signed [VW-1:0] w_re_ext;
    logic signed [VW-1:0] w_im_ext;
    logic signed [VW-1:0] w_mean_ext;

    assign s_axis_tready = (r_state == fwa_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Effective frame length and position.
    always_comb begin
        w_sc_ext = 32'(r_sample_count);
        if (w_sc_ext == 32'd0) w_n = NBITS'(1);
        else if (w_sc_ext > 32'(MAX_FRAME)) w_n = NBITS'(MAX_FRAME);
        else w_n = NBITS'(w_sc_ext);
        if (NBITS'(r_index) >= w_n) w_i = IDXW'(w_n - 1'b1);
        else w_i = r_index;
        w_last = (NBITS'(w_i) == (w_n - 1'b1));
    end

    // Divider operands for the selected window.
    always_comb begin
        w_nn     = NUMW'(w_n);
        w_two_i  = NUMW'(w_i) << 1;
        w_two_i1 = w_two_i + NUMW'(1);
        w_d_pw   = (w_two_i1 >= w_nn) ? (w_two_i1 - w_nn) : (w_nn - w_two_i1);
        w_d_q    = (w_two_i >= w_nn) ? (w_two_i - w_nn) : (w_nn - w_two_i);
        w_num      = '0;
        w_den      = DENW'(1);
        w_need_div = 1'b0;
        unique case (r_window_type) inside
            fwa_pkg::WIN_HANN: begin
                w_num      = NUMW'(w_i) * NUMW'(8 * D) + w_nn;
                w_den      = DENW'(w_n) << 1;
                w_need_div = 1'b1;
            end
            fwa_pkg::WIN_PARZEN, fwa_pkg::WIN_WELCH: begin
                w_num      = (w_d_pw << F) + ((w_nn + NUMW'(1)) >> 1);
                w_den      = DENW'(w_n) + DENW'(1);
                w_need_div = 1'b1;
            end
            fwa_pkg::WIN_QUAD: begin
                w_num      = (w_d_q << F) + (w_nn >> 1);
                w_den      = DENW'(w_n);
                w_need_div = 1'b1;
            end
            default: begin
                w_need_div = 1'b0;
            end
        endcase
    end

    fwa_div #(
        .NUMW (NUMW),
        .DENW (DENW),
        .QW   (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_need_div),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Hann phase to quadrant and table address.
    always_comb begin
        w_p = w_quot[PHW-1:0];
        if (w_p >= PHW'(3 * D)) begin
            w_quad = 2'd3;
            w_rr   = w_p - PHW'(3 * D);
        end else if (w_p >= PHW'(2 * D)) begin
            w_quad = 2'd2;
            w_rr   = w_p - PHW'(2 * D);
        end else if (w_p >= PHW'(D)) begin
            w_quad = 2'd1;
            w_rr   = w_p - PHW'(D);
        end else begin
            w_quad = 2'd0;
            w_rr   = w_p;
        end
        w_neg      = (w_quad == 2'd1) || (w_quad == 2'd2);
        w_rom_addr = w_quad[0] ? AW'(PHW'(D) - w_rr) : AW'(w_rr);
        w_hann_tmp = w_neg ? ((F + 3)'(W_ONE) + (F + 3)'(1) + (F + 3)'(w_rom_data))
                           : ((F + 3)'(W_ONE) + (F + 3)'(1) - (F + 3)'(w_rom_data));
    end

    fwa_cos_rom #(
        .DEPTH (D),
        .F     (F),
        .AW    (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            fwa_pkg::S_SQ_T, fwa_pkg::S_SQ_U: begin
                w_mul_a = VW'(r_t);
                w_mul_b = MBW'(r_t);
            end
            fwa_pkg::S_SCL_RE: begin
                w_mul_a = r_v_re;
                w_mul_b = MBW'(r_w);
            end
            default: begin
                w_mul_a = r_v_im;
                w_mul_b = MBW'(r_w);
            end
        endcase
    end

    fwa_mul #(
        .AW (VW),
        .BW (MBW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_rnd_tmp  = (w_prod + RND_U) >> F;
    assign w_rnd      = w_rnd_tmp[F:0];
    assign w_re_ext   = VW'($signed(s_axis_tdata[31:0]));
    assign w_im_ext   = VW'($signed(s_axis_tdata[63:32]));
    assign w_mean_ext = VW'($signed(r_mean_offset));

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwa_pkg::S_IDLE: begin
                if (w_accept) n_state = w_need_div ? fwa_pkg::S_DIV : fwa_pkg::S_SCL_RE;
            end
            fwa_pkg::S_DIV: begin
                if (w_div_done) begin
                    unique case (r_kind) inside
                        fwa_pkg::WIN_HANN:   n_state = fwa_pkg::S_HANN_ADDR;
                        fwa_pkg::WIN_PARZEN: n_state = fwa_pkg::S_SCL_RE;
                        default:             n_state = fwa_pkg::S_SQ_T;
                    endcase
                end
            end
            fwa_pkg::S_HANN_ADDR: n_state = fwa_pkg::S_HANN_W;
            fwa_pkg::S_HANN_W:    n_state = fwa_pkg::S_SCL_RE;
            fwa_pkg::S_SQ_T:      n_state = fwa_pkg::S_SQ_T_RES;
            fwa_pkg::S_SQ_T_RES: begin
                n_state = (r_kind == fwa_pkg::WIN_QUAD) ? fwa_pkg::S_SQ_U : fwa_pkg::S_SCL_RE;
            end
            fwa_pkg::S_SQ_U:      n_state = fwa_pkg::S_SQ_U_RES;
            fwa_pkg::S_SQ_U_RES:  n_state = fwa_pkg::S_SCL_RE;
            fwa_pkg::S_SCL_RE:    n_state = fwa_pkg::S_SCL_IM;
            fwa_pkg::S_SCL_IM:    n_state = fwa_pkg::S_DONE;
            fwa_pkg::S_DONE: begin
                if (w_out_free) n_state = fwa_pkg::S_IDLE;
            end
            default: n_state = fwa_pkg::S_IDLE;
        endcase
    end

    // Control state: configuration, frame index, sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_type  <= 3'd0;
            r_sample_count <= 17'd1024;
            r_mean_offset  <= '0;
            r_complex_mode <= 1'b0;
            r_index        <= '0;
            r_state        <= fwa_pkg::S_IDLE;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fwa_pkg::REG_WINDOW_TYPE:  r_window_type  <= i_cfg_data[2:0];
                    fwa_pkg::REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[16:0];
                    fwa_pkg::REG_MEAN_OFFSET:  r_mean_offset  <= i_cfg_data;
                    fwa_pkg::REG_COMPLEX_MODE: r_complex_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) r_index <= w_last ? '0 : (w_i + 1'b1);
            if (r_state == fwa_pkg::S_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= r_window_type;
            r_cplx <= r_complex_mode;
            r_last <= w_last;
            r_v_re <= r_complex_mode ? w_re_ext : (w_re_ext - w_mean_ext);
            r_v_im <= r_complex_mode ? w_im_ext : '0;
            if (!w_need_div) r_w <= W_ONE;
        end
        case (r_state)
            fwa_pkg::S_DIV: begin
                if (w_div_done) begin
                    r_w <= W_ONE - w_quot[F:0];
                    r_t <= w_quot[F:0];
                end
            end
            fwa_pkg::S_HANN_W: r_w <= w_hann_tmp[F+1:1];
            fwa_pkg::S_SQ_T_RES: begin
                r_w <= W_ONE - w_rnd;
                r_t <= W_ONE - w_rnd;
            end
            fwa_pkg::S_SQ_U_RES: r_w <= w_rnd;
            fwa_pkg::S_SCL_IM:   r_res_re <= scale_out(w_prod);
            fwa_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out_re   <= r_res_re;
                    r_out_im   <= r_cplx ? scale_out(w_prod) : '0;
                    r_out_last <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tlast  = r_out_last;

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwa_pkg::S_IDLE) |-> !w_div_busy)
        else $error("divider busy while sequencer is idle");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while a sample is in work");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwa_pkg::S_SCL_RE) |-> (r_w <= W_ONE))
        else $error("window coefficient above unity");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fwa_pkg::S_DONE && w_out_free) |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

// ===== hdl/fwa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; the caller guarantees the quotient fits in QW bits.
module fwa_div #(
    parameter int NUMW = 40,
    parameter int DENW = 18,
    parameter int QW   = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_busy,
    output logic            o_done,
    output logic [QW-1:0]   o_quot
);
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DENW:0]   r_rem;
    logic [QW-1:0]   r_q;
    logic [DENW-1:0] r_den;
    logic [DENW:0]   w_shift;
    logic            w_ge;

    assign w_shift = {r_rem[DENW-1:0], r_q[QW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The upper numerator bits are already below the divisor, so only QW steps remain.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DENW + 1)'(i_num >> QW);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/fwa_cos_rom.sv =====
// Quarter-wave cosine table in unsigned Q1.F, registered read.
// Entries are built at elaboration with a 64-bit fixed-point (61 fraction bits) Taylor series.
module fwa_cos_rom #(
    parameter int DEPTH = 1024,
    parameter int F     = 18,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr,
    output logic [F:0]    o_data
);
    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q61     = 64'd1 << 61;
    localparam logic [63:0] TAYLOR_DIV [1:14] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
    };

    function automatic logic [F:0] cos_entry(input int unsigned k);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  t;
        logic [127:0] pr;
        x = (HALF_PI_Q61 / 64'(DEPTH)) * 64'(k)
            + ((HALF_PI_Q61 % 64'(DEPTH)) * 64'(k)) / 64'(DEPTH);
        pr = 128'(x) * 128'(x);
        x2 = pr[124:61];
        sum = ONE_Q61;
        term = ONE_Q61;
        for (int n = 1; n <= 14; n++) begin
            pr = 128'(term) * 128'(x2);
            term = pr[124:61] / TAYLOR_DIV[n];
            if ((n & 1) == 1) sum = sum - term;
            else sum = sum + term;
        end
        if (sum >= (64'd1 << 62)) return '0;
        t = (sum + (64'd1 << (60 - F))) >> (61 - F);
        if (t > (64'd1 << F)) t = 64'd1 << F;
        return t[F:0];
    endfunction

    logic [F:0] w_tab [DEPTH+1];
    logic [F:0] r_data;

    for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
        assign w_tab[g] = cos_entry(g);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== hdl/fwa_mul.sv =====
// Shared signed multiplier with a registered product.
// Standalone; operands are selected by the sequencer in the top level.
module fwa_mul #(
    parameter int AW = 33,
    parameter int BW = 20
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    logic signed [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
